// ===== hdl/allfl_pkg.sv =====
// ============================================================================
// allfl_pkg
// Shared types, codes and microcode for the linked-list slot store with a
// free list.
// ============================================================================
`default_nettype none

package allfl_pkg;

    // Request and response payloads
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] item_value;
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [2:0] slot;
    } t_rsp;

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Microprogram step addresses
    typedef logic [3:0] t_step;

    localparam t_step STEP_IDLE      = 4'd0;
    localparam t_step STEP_PUSH_LD   = 4'd1;
    localparam t_step STEP_PUSH_WR   = 4'd2;
    localparam t_step STEP_POP_LD    = 4'd3;
    localparam t_step STEP_POP_WR    = 4'd4;
    localparam t_step STEP_RM_LD     = 4'd5;
    localparam t_step STEP_RM_TEST   = 4'd6;
    localparam t_step STEP_RM_NEXT   = 4'd7;
    localparam t_step STEP_RM_UNLINK = 4'd8;
    localparam t_step STEP_RPT_DONE  = 4'd9;
    localparam t_step STEP_RPT_FULL  = 4'd10;
    localparam t_step STEP_RPT_EMPTY = 4'd11;
    localparam t_step STEP_RPT_NF    = 4'd12;

    // Datapath actions
    typedef enum logic [2:0] {
        ACT_NOP      = 3'd0,
        ACT_CUR_FREE = 3'd1,
        ACT_PUSH     = 3'd2,
        ACT_CUR_HEAD = 3'd3,
        ACT_POP      = 3'd4,
        ACT_ADVANCE  = 3'd5,
        ACT_UNLINK   = 3'd6,
        ACT_REPORT   = 3'd7
    } t_act;

    // Branch conditions
    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_DISPATCH = 3'd1,
        COND_FREE_NIL = 3'd2,
        COND_HEAD_NIL = 3'd3,
        COND_MATCH    = 3'd4,
        COND_LAST     = 3'd5,
        COND_OUT_FREE = 3'd6
    } t_cond;

    typedef struct packed {
        t_act    act;
        t_status status;
        t_cond   cond;
        t_step   jt;
        t_step   jf;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic free_nil;
        logic head_nil;
        logic match;
        logic last;
        logic out_free;
    } t_flags;

    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        w = '{act: ACT_NOP, status: ST_DONE, cond: COND_ALWAYS,
              jt: STEP_IDLE, jf: STEP_IDLE};
        unique case (step)
            STEP_IDLE: begin
                w = '{ACT_NOP, ST_DONE, COND_DISPATCH, STEP_IDLE, STEP_IDLE};
            end
            STEP_PUSH_LD: begin
                w = '{ACT_CUR_FREE, ST_DONE, COND_FREE_NIL, STEP_RPT_FULL, STEP_PUSH_WR};
            end
            STEP_PUSH_WR: begin
                w = '{ACT_PUSH, ST_DONE, COND_ALWAYS, STEP_RPT_DONE, STEP_RPT_DONE};
            end
            STEP_POP_LD: begin
                w = '{ACT_CUR_HEAD, ST_DONE, COND_HEAD_NIL, STEP_RPT_EMPTY, STEP_POP_WR};
            end
            STEP_POP_WR: begin
                w = '{ACT_POP, ST_DONE, COND_ALWAYS, STEP_RPT_DONE, STEP_RPT_DONE};
            end
            STEP_RM_LD: begin
                w = '{ACT_CUR_HEAD, ST_DONE, COND_HEAD_NIL, STEP_RPT_EMPTY, STEP_RM_TEST};
            end
            STEP_RM_TEST: begin
                w = '{ACT_NOP, ST_DONE, COND_MATCH, STEP_RM_UNLINK, STEP_RM_NEXT};
            end
            STEP_RM_NEXT: begin
                w = '{ACT_ADVANCE, ST_DONE, COND_LAST, STEP_RPT_NF, STEP_RM_TEST};
            end
            STEP_RM_UNLINK: begin
                w = '{ACT_UNLINK, ST_DONE, COND_ALWAYS, STEP_RPT_DONE, STEP_RPT_DONE};
            end
            STEP_RPT_DONE: begin
                w = '{ACT_REPORT, ST_DONE, COND_OUT_FREE, STEP_IDLE, STEP_RPT_DONE};
            end
            STEP_RPT_FULL: begin
                w = '{ACT_REPORT, ST_FULL, COND_OUT_FREE, STEP_IDLE, STEP_RPT_FULL};
            end
            STEP_RPT_EMPTY: begin
                w = '{ACT_REPORT, ST_EMPTY, COND_OUT_FREE, STEP_IDLE, STEP_RPT_EMPTY};
            end
            STEP_RPT_NF: begin
                w = '{ACT_REPORT, ST_NOT_FOUND, COND_OUT_FREE, STEP_IDLE, STEP_RPT_NF};
            end
            default: begin
                w = '{ACT_NOP, ST_DONE, COND_ALWAYS, STEP_IDLE, STEP_IDLE};
            end
        endcase
        return w;
    endfunction

    // Entry point of each operation; the unused mode reports not found.
    function automatic t_step dispatch(input logic [1:0] mode);
        t_step s;
        s = STEP_RPT_NF;
        unique case (mode)
            MODE_PUSH:   s = STEP_PUSH_LD;
            MODE_POP:    s = STEP_POP_LD;
            MODE_REMOVE: s = STEP_RM_LD;
            default:     s = STEP_RPT_NF;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/allfl_seq.sv =====
// ============================================================================
// allfl_seq
// Microprogram sequencer: step counter, control ROM and two-way branch logic.
// ============================================================================
`default_nettype none

module allfl_seq (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire [1:0]              i_mode,
    input  wire allfl_pkg::t_flags i_flags,
    output allfl_pkg::t_uword      o_uword
);
    import allfl_pkg::*;

    t_step  r_upc;
    t_step  n_upc;
    t_uword w_uword;
    logic   w_take;

    assign w_uword = ucode_rom(r_upc);
    assign o_uword = w_uword;

    always_comb begin
        w_take = 1'b0;
        unique case (w_uword.cond)
            COND_ALWAYS:   w_take = 1'b1;
            COND_DISPATCH: w_take = i_flags.in_valid;
            COND_FREE_NIL: w_take = i_flags.free_nil;
            COND_HEAD_NIL: w_take = i_flags.head_nil;
            COND_MATCH:    w_take = i_flags.match;
            COND_LAST:     w_take = i_flags.last;
            COND_OUT_FREE: w_take = i_flags.out_free;
            default:       w_take = 1'b1;
        endcase
    end

    always_comb begin
        if (w_take) begin
            n_upc = (w_uword.cond == COND_DISPATCH) ? dispatch(i_mode) : w_uword.jt;
        end else begin
            n_upc = w_uword.jf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= STEP_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/array_linked_list_free_list.sv =====
// ============================================================================
// array_linked_list_free_list
// Slot store holding a singly linked list and a free list of unused slots,
// driven by a small microprogram.
// ============================================================================
// Push and pop load the slot, write the links and then report; a full store or an
// empty list reports after the load, and the unused mode reports at once. Remove
// compares at most DEPTH slots, each through a test and an advance microstep
// through the link memory. The next request can be taken in the cycle after the
// response is registered; a held response stalls the report.
// Reset (synchronous) empties the list and restores the free list in order.
`default_nettype none

module array_linked_list_free_list #(
    parameter int DEPTH      = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire allfl_pkg::t_req i_req,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output allfl_pkg::t_rsp     o_rsp
);
    import allfl_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int PTR_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] NIL      = PTR_W'(DEPTH);
    localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(DEPTH - 1);

    // Slot memories
    logic [DATA_WIDTH-1:0] r_vals  [DEPTH];
    logic [PTR_W-1:0]      r_used  [DEPTH];
    logic [PTR_W-1:0]      r_free  [DEPTH];
    logic [DEPTH-1:0]      r_free_vld;

    logic [DATA_WIDTH-1:0] r_vrd;
    logic [PTR_W-1:0]      r_urd;
    logic [PTR_W-1:0]      r_frd;

    logic [DATA_WIDTH-1:0] r_val;
    logic [PTR_W-1:0]      r_list_head;
    logic [PTR_W-1:0]      r_free_head;
    logic [PTR_W-1:0]      r_cur;
    logic [PTR_W-1:0]      n_cur;
    logic [PTR_W-1:0]      r_prev;
    logic [IDX_W-1:0]      r_cnt;

    logic                  r_out_valid;
    t_rsp                  r_rsp;

    t_uword                w_uw;
    t_flags                w_flags;
    logic                  w_accept;
    logic                  w_rpt;
    logic [IDX_W-1:0]      w_rd_addr;
    logic [IDX_W-1:0]      w_cur_idx;
    logic [IDX_W-1:0]      w_prev_idx;
    logic [DATA_WIDTH+31:0] w_val_ext;
    logic [IDX_W+2:0]      w_slot_ext;

    allfl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (i_req.mode),
        .i_flags (w_flags),
        .o_uword (w_uw)
    );

    assign o_in_ready  = (w_uw.cond == COND_DISPATCH);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    assign w_val_ext  = {{DATA_WIDTH{1'b0}}, i_req.item_value};
    assign w_cur_idx  = r_cur[IDX_W-1:0];
    assign w_prev_idx = r_prev[IDX_W-1:0];
    assign w_slot_ext = {3'b000, w_cur_idx};

    always_comb begin
        w_flags.in_valid = i_in_valid;
        w_flags.free_nil = (r_free_head == NIL);
        w_flags.head_nil = (r_list_head == NIL);
        w_flags.match    = (r_vrd == r_val);
        w_flags.last     = (r_urd == NIL) || (r_cnt == CNT_LAST);
        w_flags.out_free = !r_out_valid || i_out_ready;
    end

    assign w_rpt = (w_uw.act == ACT_REPORT) && w_flags.out_free;

    // The memories are read at the slot that r_cur takes next, so the read
    // data always belongs to the current slot.
    always_comb begin
        n_cur = r_cur;
        case (w_uw.act)
            ACT_CUR_FREE: n_cur = r_free_head;
            ACT_CUR_HEAD: n_cur = r_list_head;
            ACT_ADVANCE:  n_cur = r_urd;
            default:      n_cur = r_cur;
        endcase
    end
    assign w_rd_addr = n_cur[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        r_vrd <= r_vals[w_rd_addr];
        r_urd <= r_used[w_rd_addr];
        r_frd <= r_free_vld[w_rd_addr] ? r_free[w_rd_addr]
                                       : PTR_W'(w_rd_addr) + PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.act == ACT_PUSH) begin
            r_vals[w_cur_idx] <= r_val;
        end
        if (w_uw.act == ACT_PUSH) begin
            r_used[w_cur_idx] <= r_list_head;
        end else if (w_uw.act == ACT_UNLINK && r_prev != NIL) begin
            r_used[w_prev_idx] <= r_urd;
        end
        if (w_uw.act == ACT_POP || w_uw.act == ACT_UNLINK) begin
            r_free[w_cur_idx] <= r_free_head;
        end
    end

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (w_accept) begin
            r_val <= w_val_ext[DATA_WIDTH-1:0];
        end
        case (w_uw.act)
            ACT_CUR_HEAD: begin
                r_prev <= NIL;
                r_cnt  <= '0;
            end
            ACT_ADVANCE: begin
                r_prev <= r_cur;
                r_cnt  <= r_cnt + IDX_W'(1);
            end
            default: ;
        endcase
        if (w_rpt) begin
            r_rsp.status <= w_uw.status;
            r_rsp.slot   <= (w_uw.status == ST_DONE) ? w_slot_ext[2:0] : 3'b000;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head <= NIL;
            r_free_head <= '0;
            r_free_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (w_uw.act)
                ACT_PUSH: begin
                    r_free_head <= r_frd;
                    r_list_head <= r_cur;
                end
                ACT_POP: begin
                    r_list_head <= r_urd;
                    r_free_head <= r_cur;
                    r_free_vld[w_cur_idx] <= 1'b1;
                end
                ACT_UNLINK: begin
                    if (r_prev == NIL) begin
                        r_list_head <= r_urd;
                    end
                    r_free_head <= r_cur;
                    r_free_vld[w_cur_idx] <= 1'b1;
                end
                default: ;
            endcase
            if (w_rpt) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Assertions
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rsp.status != ST_DONE) |-> (o_rsp.slot == 3'b000))
        else $error("slot is not zero on a failed request");

    a_heads_not_both_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_list_head == NIL) && (r_free_head == NIL)))
        else $error("list and free list are both empty");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("request taken while the previous one is in progress");

    a_commit_on_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uw.act == ACT_PUSH || w_uw.act == ACT_POP || w_uw.act == ACT_UNLINK)
        |-> (r_cur != NIL))
        else $error("list update on a null slot");

    a_report_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rpt |=> o_out_valid)
        else $error("response lost");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Bench for the slot store that keeps a linked list and a free list of slots.
// A queue of pending requests feeds a clocked driver. A clocked monitor
// compares every response, field by field, with a prediction made when its
// request was taken. Directed requests cover the corner cases. Random phases
// then alternate between filling and draining the list, with idle gaps on
// both sides, a long receiver hold-off, and a drain between phases.
// ============================================================================

module tb_top;

    import allfl_pkg::*;

    localparam int         DEPTH        = 8;
    localparam int         DATA_WIDTH   = 32;
    localparam logic [3:0] NIL          = 4'd8;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         PHASE_ITEMS  = 100;
    localparam int         LONG_HOLD    = 400;
    localparam int         LIMIT_CYCLES = 400000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_req req       = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rsp rsp;

    // Predicted contents of the store
    logic signed [31:0] slot_val [0:DEPTH-1];
    logic [3:0]         used_next[0:DEPTH-1];
    logic [3:0]         free_next[0:DEPTH-1];
    logic [3:0]         used_head;
    logic [3:0]         free_head;

    t_req pending_req[$];
    t_rsp expected_rsp[$];

    int errors        = 0;
    int cycles        = 0;
    int send_gap      = 0;
    int recv_gap      = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mode_count[4] = '{0, 0, 0, 0};
    int stat_count[4] = '{0, 0, 0, 0};

    logic hold_start  = 1'b0;
    logic hold_active = 1'b0;
    int   hold_left   = 0;

    array_linked_list_free_list #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_req       (req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_rsp       (rsp)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
    end

    function automatic void clear_lists();
        for (int i = 0; i < DEPTH; i++) begin
            slot_val[i]  = '0;
            used_next[i] = NIL;
            free_next[i] = 4'(i + 1);
        end
        used_head = NIL;
        free_head = 4'd0;
    endfunction

    // Applies one request to the predicted store and returns its response.
    function automatic t_rsp apply_list_op(input t_req r);
        t_rsp       res;
        logic [3:0] s;
        logic [3:0] prev;
        logic       hit;
        res.status = ST_NOT_FOUND;
        res.slot   = '0;
        case (r.mode)
            MODE_PUSH: begin
                if (free_head == NIL) begin
                    res.status = ST_FULL;
                end else begin
                    s            = free_head;
                    free_head    = free_next[s];
                    slot_val[s]  = r.item_value;
                    used_next[s] = used_head;
                    used_head    = s;
                    res.status   = ST_DONE;
                    res.slot     = s[2:0];
                end
            end
            MODE_POP: begin
                if (used_head == NIL) begin
                    res.status = ST_EMPTY;
                end else begin
                    s            = used_head;
                    used_head    = used_next[s];
                    free_next[s] = free_head;
                    free_head    = s;
                    res.status   = ST_DONE;
                    res.slot     = s[2:0];
                end
            end
            MODE_REMOVE: begin
                if (used_head == NIL) begin
                    res.status = ST_EMPTY;
                end else begin
                    prev = NIL;
                    s    = used_head;
                    hit  = 1'b0;
                    for (int n = 0; n < DEPTH && !hit && s != NIL; n++) begin
                        if (slot_val[s] == r.item_value) begin
                            hit = 1'b1;
                            if (prev != NIL) begin
                                used_next[prev] = used_next[s];
                            end else begin
                                used_head = used_next[s];
                            end
                            free_next[s] = free_head;
                            free_head    = s;
                            res.status   = ST_DONE;
                            res.slot     = s[2:0];
                        end else begin
                            prev = s;
                            s    = used_next[s];
                        end
                    end
                end
            end
            default: begin
                res.status = ST_NOT_FOUND;
            end
        endcase
        return res;
    endfunction

    // Mostly no gap; when there is one it is usually short and now and then long.
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(15, 50);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [31:0] pick_value(input int pool_pct);
        logic signed [31:0] pool[9];
        pool = '{32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, -32'sd1, 32'sd0,
                 32'sh7fffffff, 32'sh80000000};
        if ($urandom_range(0, 99) < pool_pct) begin
            return pool[$urandom_range(0, 8)];
        end
        return $urandom;
    endfunction

    function automatic t_req make_random_req(input int push_pct);
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            r.mode       = MODE_UNUSED;
            r.item_value = $urandom;
        end else if (pick < 2 + push_pct) begin
            r.mode       = MODE_PUSH;
            r.item_value = pick_value(60);
        end else if ($urandom_range(0, 2) == 0) begin
            r.mode       = MODE_POP;
            r.item_value = $urandom;
        end else begin
            r.mode       = MODE_REMOVE;
            r.item_value = pick_value(80);
        end
        return r;
    endfunction

    task automatic queue_req(input logic [1:0] mode, input logic signed [31:0] value);
        t_req r;
        r.mode       = mode;
        r.item_value = value;
        pending_req.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // The sender stops here until every request has been answered.
    task automatic wait_drain();
        while (pending_req.size() != 0 || in_valid || expected_rsp.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // Driver: presents requests from the pending queue, with gaps between them.
    always @(posedge clk) begin : driver
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_rsp.push_back(apply_list_op(req));
                mode_count[req.mode]++;
                send_gap = pick_gap(send_idle_pct);
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_req.size() > 0) begin
                    req      <= pending_req.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only sees a flag.
    always @(posedge clk) begin : hold_off
        if (!rst_n) begin
            hold_left   <= 0;
            hold_active <= 1'b0;
        end else if (hold_start && hold_left == 0) begin
            hold_left   <= LONG_HOLD;
            hold_active <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            hold_active <= (hold_left > 1);
        end
    end

    // Monitor: checks each response against the oldest prediction.
    always @(posedge clk) begin : monitor
        t_rsp want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response with no request outstanding", rsp.status, -1);
                end else begin
                    want = expected_rsp.pop_front();
                    stat_count[rsp.status]++;
                    if (rsp.status !== want.status) begin
                        report_mismatch("status", rsp.status, want.status);
                    end
                    if (rsp.slot !== want.slot) begin
                        report_mismatch("slot", rsp.slot, want.slot);
                    end
                end
            end
            if (recv_gap == 0) begin
                recv_gap = pick_gap(recv_idle_pct);
            end
            if (hold_active || recv_gap > 0) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
            if (recv_gap > 0) begin
                recv_gap--;
            end
        end
    end

    initial begin : watchdog
        wait (cycles >= LIMIT_CYCLES);
        $display("Timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int push_pct;
        clear_lists();

        // Corner cases, sent without idling.
        queue_req(MODE_POP, 32'sd0);
        queue_req(MODE_REMOVE, 32'sd5);
        queue_req(MODE_UNUSED, -32'sd1);
        queue_req(MODE_PUSH, 32'sh80000000);
        queue_req(MODE_REMOVE, 32'sd1);            // one slot, no match
        queue_req(MODE_REMOVE, 32'sh80000000);     // sole element removed
        queue_req(MODE_PUSH, 32'sh7fffffff);
        queue_req(MODE_PUSH, 32'sd0);
        queue_req(MODE_PUSH, -32'sd1);
        queue_req(MODE_PUSH, 32'sd1);
        queue_req(MODE_PUSH, 32'sd2);
        queue_req(MODE_PUSH, 32'sd3);
        queue_req(MODE_PUSH, 32'sd4);
        queue_req(MODE_PUSH, 32'sd5);
        queue_req(MODE_PUSH, 32'sd6);              // store is full here
        queue_req(MODE_REMOVE, 32'sh7fffffff);     // tail, full-length walk
        queue_req(MODE_REMOVE, 32'sd3);
        queue_req(MODE_REMOVE, 32'sd5);            // head
        queue_req(MODE_REMOVE, 32'sd77);           // absent value
        queue_req(MODE_UNUSED, 32'sd0);
        queue_req(MODE_POP, 32'sd0);
        queue_req(MODE_POP, 32'sd0);
        queue_req(MODE_PUSH, 32'sd9);
        queue_req(MODE_PUSH, 32'sd10);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        wait_drain();

        for (int ph = 1; ph <= 8; ph++) begin
            push_pct = (ph % 2 == 1) ? 70 : 30;
            if (ph == 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (ph == 3) begin
                send_idle_pct = 5;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = $urandom_range(10, 50);
                recv_idle_pct = $urandom_range(10, 40);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pending_req.push_back(make_random_req(push_pct));
            end
            if (ph == 3) begin
                // Receiver stops while requests keep coming, so the input stalls.
                hold_start = 1'b1;
                @(negedge clk);
                hold_start = 1'b0;
            end
            wait_drain();
        end

        repeat (2 * DEPTH + 8) @(posedge clk);

        $display("Sent %0d requests: %0d push, %0d pop, %0d remove, %0d unused mode",
                 mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
                 mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        $display("Responses seen: %0d done, %0d full, %0d empty, %0d not found",
                 stat_count[0], stat_count[1], stat_count[2], stat_count[3]);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/allfl_pkg.sv
hdl/allfl_seq.sv
hdl/array_linked_list_free_list.sv
bench/tb_top.sv
